[rtl/core/bgw_pkg.sv]
// Shared types and constants for the Bayer gray-world white balance block.
package bgw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 16;
  localparam int TOTAL_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W = 13;
  localparam logic [4:0] REJECT_MARGIN = 5'd25;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd4;

  localparam logic [1:0] ORDER_RGGB = 2'd0;
  localparam logic [1:0] ORDER_BGGR = 2'd1;
  localparam logic [1:0] ORDER_GRBG = 2'd2;
  localparam logic [1:0] ORDER_GBRG = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_top_left;
    logic [SAMPLE_W-1:0] sample_top_right;
    logic [SAMPLE_W-1:0] sample_bottom_left;
    logic [SAMPLE_W-1:0] sample_bottom_right;
  } quad_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_red;
    logic [GAIN_W-1:0] gain_green;
    logic [GAIN_W-1:0] gain_blue;
    logic red_valid;
    logic green_valid;
    logic blue_valid;
  } gains_t;

  // one quad's contribution after black subtraction
  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic reject;
  } lane_out_t;

endpackage

[rtl/core/bgw_lane.sv]
// One sample lane: black clamp and white reject test for a single sample.
module bgw_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic [bgw_pkg::SAMPLE_W-1:0] sample,
  input  logic [15:0]                  sat_level,
  input  logic [15:0]                  dark_level,
  output logic [bgw_pkg::SAMPLE_W-1:0] level,
  output logic                         reject
);
  logic [bgw_pkg::SAMPLE_W-1:0] masked;
  logic [16:0] with_margin;

  always_comb begin
    masked = sample & bgw_pkg::SAMPLE_W'((17'd1 << SAMPLE_BITS) - 17'd1);
    with_margin = {1'b0, masked} + {12'd0, bgw_pkg::REJECT_MARGIN};
    reject = with_margin > {1'b0, sat_level};
    level = (masked > dark_level) ? masked - dark_level : '0;
  end
endmodule

[rtl/core/bgw_merge.sv]
// Merge of the four lanes into red, green and blue by mosaic order.
module bgw_merge (
  input  logic [bgw_pkg::SAMPLE_W-1:0] lv [4],
  input  logic [3:0]                   rej,
  input  logic [1:0]                   order,
  output bgw_pkg::lane_out_t           px
);
  logic [1:0] r_pos, b_pos, g0, g1;
  always_comb begin
    unique case (order)
      bgw_pkg::ORDER_RGGB: begin r_pos = 2'd0; b_pos = 2'd3; g0 = 2'd1; g1 = 2'd2; end
      bgw_pkg::ORDER_BGGR: begin r_pos = 2'd3; b_pos = 2'd0; g0 = 2'd1; g1 = 2'd2; end
      bgw_pkg::ORDER_GRBG: begin r_pos = 2'd1; b_pos = 2'd2; g0 = 2'd0; g1 = 2'd3; end
      default: begin r_pos = 2'd2; b_pos = 2'd1; g0 = 2'd0; g1 = 2'd3; end
    endcase
    px.red = lv[r_pos];
    px.blue = lv[b_pos];
    px.green = {1'b0, lv[g0]} + {1'b0, lv[g1]};
    px.reject = |rej;
  end
endmodule

[rtl/core/bgw_divider.sv]
// Restoring divider: quotient of green*2048 by a channel total, saturated.
module bgw_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bgw_pkg::TOTAL_W-1:0] num,
  input  logic [bgw_pkg::TOTAL_W-1:0] den,
  output logic                        busy,
  output logic [bgw_pkg::GAIN_W-1:0]  quot
);
  localparam int NW = bgw_pkg::TOTAL_W + 11;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n;
  logic [NW-1:0] q;
  logic [bgw_pkg::TOTAL_W:0] rem;
  logic [bgw_pkg::TOTAL_W-1:0] d;
  logic [CW-1:0] cnt;
  logic [bgw_pkg::TOTAL_W:0] trial;

  always_comb begin
    trial = {rem[bgw_pkg::TOTAL_W-1:0], n[NW-1]};
    quot = (|q[NW-1:bgw_pkg::GAIN_W]) ? '1 : q[bgw_pkg::GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      n <= {num, 11'd0};
      d <= den;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      n <= {n[NW-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

[rtl/core/bayer_gray_world_white_balance_top.sv]
// Top level of the Bayer gray-world white balance block.
//
// Usage: send one 2x2 quad per item on the in channel (in_valid/in_ready,
// payload in_data) in raster order. Quads are grouped into blocks of
// BLOCK_QUADS x BLOCK_QUADS; a block with any sample above white minus 25
// is dropped, the rest accumulate into frame totals per channel.
// Per-block-column partials live in a memory with one entry per block column.
// Each quad takes a memory read stage, so in_ready drops for one cycle when a
// quad's block column equals the previous quad's pending write. A quad in a
// new block column is taken the cycle after the previous one; a quad in the
// same block column waits until the previous quad's partial is written back.
// On the last quad of a frame the block stops taking items while two serial
// dividers run, one each for the red and blue gains, each working through a
// 59-bit quotient; out_valid rises when both are done and no result is held.
// The gain item then sits in an output register (out_valid/out_data) until
// taken; a stalled receiver holds in_ready low only after a frame ends.
// Reset clears counters and totals; no clearing pass: partial entries are
// always rewritten at the top row of a block before use.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong between frames.
module bayer_gray_world_white_balance_top #(
  parameter int MAX_WIDTH_QUADS = 4096,
  parameter int BLOCK_QUADS = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bgw_pkg::quad_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bgw_pkg::gains_t               out_data,
  input  logic                          cfg_we,
  input  logic [bgw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgw_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int WMAX = (MAX_WIDTH_QUADS < 4096) ? MAX_WIDTH_QUADS : 4096;
  localparam int DEPTH = (MAX_WIDTH_QUADS + BLOCK_QUADS - 1) / BLOCK_QUADS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = 12;
  localparam int BW = $clog2(BLOCK_QUADS + 1);
  localparam int SUM_W = bgw_pkg::SAMPLE_W + 1 + 2 * $clog2(BLOCK_QUADS) + 1;
  localparam int TW = bgw_pkg::TOTAL_W;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic reject;
  } part_t;

  logic [12:0] width_quads, height_quads;
  logic [15:0] sat_level, dark_level;
  logic [1:0]  bayer_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_quads <= 13'd4096;
      height_quads <= 13'd4096;
      sat_level <= 16'hFFFF;
      dark_level <= 16'd0;
      bayer_order <= bgw_pkg::ORDER_RGGB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgw_pkg::REG_WIDTH:  width_quads <= cfg_data[12:0];
        bgw_pkg::REG_HEIGHT: height_quads <= cfg_data[12:0];
        bgw_pkg::REG_WHITE:  sat_level <= cfg_data;
        bgw_pkg::REG_BLACK:  dark_level <= cfg_data;
        bgw_pkg::REG_ORDER:  bayer_order <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions
  logic [12:0] w_eff, h_eff;
  always_comb begin
    w_eff = (width_quads == 13'd0) ? 13'd1 :
            (width_quads > 13'(WMAX)) ? 13'(WMAX) : width_quads;
    h_eff = (height_quads == 13'd0) ? 13'd1 :
            (height_quads > 13'd4096) ? 13'd4096 : height_quads;
  end

  // position counters with block-relative subcounters
  logic [PW-1:0] col, row;
  logic [BW-1:0] col_sub, row_sub;
  logic [AW-1:0] bcol;
  logic last_col, last_row;
  always_comb begin
    last_col = {1'b0, col} + 13'd1 >= w_eff;
    last_row = {1'b0, row} + 13'd1 >= h_eff;
  end

  // four sample lanes and a merge
  logic [bgw_pkg::SAMPLE_W-1:0] lv [4];
  logic [3:0] rej;
  logic [bgw_pkg::SAMPLE_W-1:0] smp [4];
  bgw_pkg::lane_out_t px;
  assign smp[0] = in_data.sample_top_left;
  assign smp[1] = in_data.sample_top_right;
  assign smp[2] = in_data.sample_bottom_left;
  assign smp[3] = in_data.sample_bottom_right;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    bgw_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .sample(smp[g]), .sat_level(sat_level), .dark_level(dark_level),
      .level(lv[g]), .reject(rej[g])
    );
  end
  bgw_merge u_merge (.lv(lv), .rej(rej), .order(bayer_order), .px(px));

  // stage 1: registered quad plus memory read
  logic s1_valid, s1_first, s1_close, s1_frame_end;
  logic [AW-1:0] s1_addr;
  bgw_pkg::lane_out_t s1_px;
  part_t mem [DEPTH];
  part_t rd;
  logic busy_frame;
  logic in_fire;
  logic hazard;

  assign hazard = s1_valid && (s1_addr == bcol);
  assign in_ready = !busy_frame && !hazard;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) rd <= mem[bcol];
  end

  // accumulate into the partial and write it back
  part_t upd;
  always_comb begin
    if (s1_first) begin
      upd = '0;
    end else begin
      upd = rd;
    end
    upd.red = upd.red + SUM_W'(s1_px.red);
    upd.green = upd.green + SUM_W'(s1_px.green);
    upd.blue = upd.blue + SUM_W'(s1_px.blue);
    upd.reject = upd.reject | s1_px.reject;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) mem[s1_addr] <= upd;
  end

  logic [TW-1:0] tot_r, tot_g, tot_b;
  logic div_start;
  logic div_busy_r, div_busy_b;
  logic [bgw_pkg::GAIN_W-1:0] q_r, q_b;
  logic wait_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; col_sub <= '0; row_sub <= '0; bcol <= '0;
      s1_valid <= 1'b0;
      busy_frame <= 1'b0;
      tot_r <= '0; tot_g <= '0; tot_b <= '0;
      div_start <= 1'b0;
      wait_div <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      s1_valid <= in_fire;
      if (in_fire) begin
        s1_addr <= bcol;
        s1_px <= px;
        s1_first <= (col_sub == '0) && (row_sub == '0);
        s1_close <= (last_col || col_sub == BW'(BLOCK_QUADS - 1)) &&
                    (last_row || row_sub == BW'(BLOCK_QUADS - 1));
        s1_frame_end <= last_col && last_row;
        if (!last_col) begin
          col <= col + 1'b1;
          if (col_sub == BW'(BLOCK_QUADS - 1)) begin
            col_sub <= '0;
            bcol <= (bcol == AW'(DEPTH - 1)) ? '0 : bcol + 1'b1;
          end else begin
            col_sub <= col_sub + 1'b1;
          end
        end else begin
          col <= '0; col_sub <= '0; bcol <= '0;
          if (!last_row) begin
            row <= row + 1'b1;
            row_sub <= (row_sub == BW'(BLOCK_QUADS - 1)) ? '0 : row_sub + 1'b1;
          end else begin
            row <= '0; row_sub <= '0;
            busy_frame <= 1'b1;
          end
        end
      end
      if (s1_valid) begin
        if (s1_close && !upd.reject) begin
          tot_r <= tot_r + TW'(upd.red);
          tot_g <= tot_g + TW'(upd.green);
          tot_b <= tot_b + TW'(upd.blue);
        end
        if (s1_frame_end) div_start <= 1'b1;
      end
      if (div_start) wait_div <= 1'b1;
      if (wait_div && !div_busy_r && !div_busy_b && !out_valid) begin
        wait_div <= 1'b0;
        out_valid <= 1'b1;
        out_data.green_valid <= tot_g != '0;
        out_data.red_valid <= (tot_g != '0) && (tot_r != '0);
        out_data.blue_valid <= (tot_g != '0) && (tot_b != '0);
        out_data.gain_green <= (tot_g != '0) ? 16'd4096 : 16'd0;
        out_data.gain_red <= ((tot_g != '0) && (tot_r != '0)) ? q_r : '0;
        out_data.gain_blue <= ((tot_g != '0) && (tot_b != '0)) ? q_b : '0;
        tot_r <= '0; tot_g <= '0; tot_b <= '0;
        busy_frame <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  bgw_divider u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .num(tot_g), .den(tot_r),
    .busy(div_busy_r), .quot(q_r)
  );
  bgw_divider u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .num(tot_g), .den(tot_b),
    .busy(div_busy_b), .quot(q_b)
  );
endmodule

[rtl/core/bgw_checker.sv]
// Port-level checks for the white balance top level, with its bind.
module bgw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input bgw_pkg::gains_t out_data
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before it was taken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");
  a_green: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.green_valid == (out_data.gain_green == 16'd4096)))
    else $error("green gain disagrees with its flag");
  a_red_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.red_valid |-> out_data.green_valid)
    else $error("red valid without green");
  a_blue_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.blue_valid |-> out_data.gain_blue == 16'd0)
    else $error("invalid blue gain not zero");
endmodule

bind bayer_gray_world_white_balance_top bgw_checker u_bgw_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
